/* hw/rtl/bgh_pkg.sv */
// Shared types, widths, the charge threshold table and threshold functions for the battery gauge.
package bgh_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 12;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TH_W       = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECT_THRESHOLD = 3'd0,
        CFG_SETTLE_PERIODS    = 3'd1,
        CFG_CONFIRM_LIMIT     = 3'd2,
        CFG_TICKS_PER_UPDATE  = 3'd3,
        CFG_INPUT_OFFSET      = 3'd4,
        CFG_INPUT_SCALE       = 3'd5,
        CFG_BATT_SCALE        = 3'd6,
        CFG_KEY_MIN_VOLTAGE   = 3'd7
    } bgh_cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IN_START,
        S_IN_WAIT,
        S_BATT_MUL,
        S_BATT_START,
        S_BATT_WAIT,
        S_SCAN,
        S_CAP,
        S_OUT
    } bgh_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } bgh_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } bgh_div_rsp_t;

    // Charge thresholds in 0.01 V, highest level first
    localparam logic [TH_W-1:0] CHARGE_TH [0:15] = '{
        9'd420, 9'd415, 9'd410, 9'd400, 9'd395, 9'd385, 9'd375, 9'd365,
        9'd355, 9'd345, 9'd335, 9'd325, 9'd315, 9'd305, 9'd295, 9'd285
    };

    function automatic logic [TH_W-1:0] charge_th(input logic [3:0] idx);
        return CHARGE_TH[idx];
    endfunction

    function automatic logic [TH_W-1:0] discharge_th(input logic [3:0] idx);
        return 9'd400 - (9'(idx) * 9'd10);
    endfunction

endpackage

/* hw/rtl/battery_gauge_hysteresis_core.sv */
// Battery gauge: input/battery voltage, capacity with hysteresis, key pulse.
//
// One input transaction per tick carries the key request and three ADC
// samples; one output transaction returns capacity, input and battery
// voltage, the connect flag and the key drive level.
// Both channels use valid/stall. The input side stalls while a tick is
// being worked on; the result sits in an output register, so the next tick
// is taken while a finished result still waits for the receiver.
// A tick without a capacity update takes one multiply and a divide on the
// shared divider. An update tick adds a second multiply and divide and,
// once the settle count is zero, a threshold scan over up to LEVELS + 1
// levels. The divider produces one quotient bit per cycle. A stalled
// receiver holds the last finished tick in the output register.
// Reset clears all gauge state, loads the register defaults and empties the
// output register. Configuration is written through cfg_we/cfg_index/
// cfg_wdata, by the user only while the block is idle; the block does not enforce this.
module battery_gauge_hysteresis_core
    import bgh_pkg::*;
#(
    parameter int LEVELS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  key_request,
    input  logic [SAMPLE_W-1:0]   input_sample,
    input  logic [SAMPLE_W-1:0]   batt_sample,
    input  logic [SAMPLE_W-1:0]   ref_sample,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            capacity_pct,
    output logic [7:0]            input_volts,
    output logic [15:0]           batt_volts,
    output logic                  power_connected,
    output logic                  key_drive
);

    localparam int IDX_W = $clog2(LEVELS + 1);

    // configuration
    logic [7:0]  thr_reg;
    logic [5:0]  settle_per_reg;
    logic [3:0]  confirm_lim_reg;
    logic [6:0]  tpu_reg;
    logic [7:0]  in_offset_reg;
    logic [7:0]  in_scale_reg;
    logic [7:0]  batt_scale_reg;
    logic [15:0] key_min_reg;

    // gauge state
    bgh_state_t  state_reg, state_next;
    logic [15:0] batt_level_reg, batt_level_next;
    logic [6:0]  cap_level_reg, cap_level_next;
    logic [7:0]  in_level_reg, in_level_next;
    logic [6:0]  tick_reg, tick_next;
    logic [5:0]  settle_reg, settle_next;
    logic [3:0]  confirm_reg, confirm_next;
    logic        key_armed_reg, key_armed_next;
    logic        key_level_reg, key_level_next;
    logic        conn_prev_reg, conn_prev_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // working registers
    logic [SAMPLE_W-1:0]   bs_reg, bs_next;
    logic [SAMPLE_W-1:0]   rs_reg, rs_next;
    logic [DIVIDEND_W-1:0] prod_reg, prod_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out_cap_reg, out_cap_next;
    logic [7:0]  out_in_reg, out_in_next;
    logic [15:0] out_batt_reg, out_batt_next;
    logic        out_conn_reg, out_conn_next;
    logic        out_key_reg, out_key_next;

    bgh_div_req_t div_req;
    bgh_div_rsp_t div_rsp;

    logic                  in_accept;
    logic                  out_free;
    logic                  ref_zero;
    logic                  div_ready;
    logic [7:0]            mul_a;
    logic [SAMPLE_W-1:0]   mul_b;
    logic [DIVIDEND_W-1:0] mul_p;
    logic [DIVIDEND_W:0]   in_sum;
    logic [7:0]            in_calc;
    logic                  conn_calc;
    logic [7:0]            tick_inc;
    logic                  upd_due;
    logic [15:0]           batt_calc;
    logic                  charging;
    logic [4:0]            idx_ext;
    logic [TH_W-1:0]       th;
    logic                  scan_end;
    logic                  scan_hit;
    logic [6:0]            tgt;
    logic [4:0]            confirm_inc;
    logic [3:0]            confirm_need;
    logic                  key_lvl_tmp;
    logic                  key_arm_tmp;
    logic [6:0]            target_tab [0:LEVELS];

    genvar gk;
    generate
        for (gk = 0; gk <= LEVELS; gk++)
        begin : g_target
            assign target_tab[gk] = 7'((LEVELS - gk) * 100 / LEVELS);
        end
    endgenerate

    bgh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign ref_zero  = (rs_reg == '0);
    assign div_ready = ref_zero || div_rsp.done;

    // shared multiplier: input channel at accept, battery channel later
    assign mul_a = (state_reg == S_IDLE) ? in_scale_reg : batt_scale_reg;
    assign mul_b = (state_reg == S_IDLE) ? input_sample : bs_reg;
    assign mul_p = DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b);

    assign in_sum    = (DIVIDEND_W + 1)'(div_rsp.quotient) + (DIVIDEND_W + 1)'(in_offset_reg);
    assign in_calc   = ref_zero ? 8'hFF
                     : ((in_sum > (DIVIDEND_W + 1)'(255)) ? 8'hFF : in_sum[7:0]);
    assign conn_calc = in_calc > thr_reg;
    assign tick_inc  = {1'b0, tick_reg} + 8'd1;
    assign upd_due   = tick_inc > {1'b0, tpu_reg};
    assign batt_calc = (ref_zero || (|div_rsp.quotient[DIVIDEND_W-1:16])) ? 16'hFFFF
                     : div_rsp.quotient[15:0];

    assign charging = in_level_reg > thr_reg;
    assign idx_ext  = 5'(idx_reg);
    assign th       = charging ? charge_th(idx_ext[3:0]) : discharge_th(idx_ext[3:0]);
    assign scan_end = (idx_reg == IDX_W'(LEVELS));
    assign scan_hit = batt_level_reg > 16'(th);
    assign tgt      = target_tab[idx_reg];
    assign confirm_inc  = {1'b0, confirm_reg} + 5'd1;
    // an empty battery while discharging takes one update
    assign confirm_need = (!charging && (tgt == '0)) ? 4'd0 : confirm_lim_reg;

    always_comb
    begin
        key_lvl_tmp = key_level_reg;
        key_arm_tmp = key_armed_reg;
        if (key_request && (batt_level_reg >= key_min_reg))
        begin
            key_lvl_tmp = 1'b1;
            key_arm_tmp = 1'b0;
        end
        // one-tick pulse: arm on the first tick, drop on the second
        if (key_lvl_tmp)
        begin
            if (!key_arm_tmp)
            begin
                key_arm_tmp = 1'b1;
            end
            else
            begin
                key_lvl_tmp = 1'b0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_IN_START;
                end
            end
            S_IN_START:
            begin
                state_next = S_IN_WAIT;
            end
            S_IN_WAIT:
            begin
                if (div_ready)
                begin
                    state_next = upd_due ? S_BATT_MUL : S_OUT;
                end
            end
            S_BATT_MUL:
            begin
                state_next = S_BATT_START;
            end
            S_BATT_START:
            begin
                state_next = S_BATT_WAIT;
            end
            S_BATT_WAIT:
            begin
                if (div_ready)
                begin
                    state_next = (settle_reg != '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end || scan_hit)
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state-driven outputs
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        div_req.start    = ((state_reg == S_IN_START) || (state_reg == S_BATT_START))
                           && !ref_zero;
        div_req.dividend = prod_reg;
        div_req.divisor  = rs_reg;
    end

    // datapath
    always_comb
    begin
        batt_level_next = batt_level_reg;
        cap_level_next  = cap_level_reg;
        in_level_next   = in_level_reg;
        tick_next       = tick_reg;
        settle_next     = settle_reg;
        confirm_next    = confirm_reg;
        key_armed_next  = key_armed_reg;
        key_level_next  = key_level_reg;
        conn_prev_next  = conn_prev_reg;
        idx_next        = idx_reg;
        bs_next         = bs_reg;
        rs_next         = rs_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_cap_next    = out_cap_reg;
        out_in_next     = out_in_reg;
        out_batt_next   = out_batt_reg;
        out_conn_next   = out_conn_reg;
        out_key_next    = out_key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    key_level_next = key_lvl_tmp;
                    key_armed_next = key_arm_tmp;
                    bs_next        = batt_sample;
                    rs_next        = ref_sample;
                    prod_next      = mul_p;
                end
            end
            S_IN_WAIT:
            begin
                if (div_ready)
                begin
                    in_level_next = in_calc;
                    if (conn_calc != conn_prev_reg)
                    begin
                        conn_prev_next = conn_calc;
                        settle_next    = settle_per_reg;
                    end
                    tick_next = upd_due ? '0 : tick_inc[6:0];
                end
            end
            S_BATT_MUL:
            begin
                prod_next = mul_p;
            end
            S_BATT_WAIT:
            begin
                if (div_ready)
                begin
                    batt_level_next = batt_calc;
                    idx_next        = '0;
                    if (settle_reg != '0)
                    begin
                        settle_next = settle_reg - 6'd1;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_end && !scan_hit)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_CAP:
            begin
                if (charging ? (tgt > cap_level_reg) : (tgt < cap_level_reg))
                begin
                    if (confirm_inc > {1'b0, confirm_need})
                    begin
                        confirm_next   = '0;
                        cap_level_next = tgt;
                    end
                    else
                    begin
                        confirm_next = confirm_inc[3:0];
                    end
                end
                else
                begin
                    confirm_next = '0;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cap_next   = cap_level_reg;
                    out_in_next    = in_level_reg;
                    out_batt_next  = batt_level_reg;
                    out_conn_next  = in_level_reg > thr_reg;
                    out_key_next   = key_level_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            batt_level_reg <= '0;
            cap_level_reg  <= '0;
            in_level_reg   <= '0;
            tick_reg       <= '0;
            settle_reg     <= '0;
            confirm_reg    <= '0;
            key_armed_reg  <= 1'b0;
            key_level_reg  <= 1'b0;
            conn_prev_reg  <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            batt_level_reg <= batt_level_next;
            cap_level_reg  <= cap_level_next;
            in_level_reg   <= in_level_next;
            tick_reg       <= tick_next;
            settle_reg     <= settle_next;
            confirm_reg    <= confirm_next;
            key_armed_reg  <= key_armed_next;
            key_level_reg  <= key_level_next;
            conn_prev_reg  <= conn_prev_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bs_reg       <= bs_next;
        rs_reg       <= rs_next;
        prod_reg     <= prod_next;
        out_cap_reg  <= out_cap_next;
        out_in_reg   <= out_in_next;
        out_batt_reg <= out_batt_next;
        out_conn_reg <= out_conn_next;
        out_key_reg  <= out_key_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= 8'd90;
            settle_per_reg  <= 6'd30;
            confirm_lim_reg <= 4'd5;
            tpu_reg         <= 7'd100;
            in_offset_reg   <= 8'd8;
            in_scale_reg    <= 8'd72;
            batt_scale_reg  <= 8'd122;
            key_min_reg     <= 16'd300;
        end
        else if (cfg_we)
        begin
            unique case (bgh_cfg_idx_t'(cfg_index))
                CFG_CONNECT_THRESHOLD: thr_reg         <= cfg_wdata[7:0];
                CFG_SETTLE_PERIODS:    settle_per_reg  <= cfg_wdata[5:0];
                CFG_CONFIRM_LIMIT:     confirm_lim_reg <= cfg_wdata[3:0];
                CFG_TICKS_PER_UPDATE:  tpu_reg         <= cfg_wdata[6:0];
                CFG_INPUT_OFFSET:      in_offset_reg   <= cfg_wdata[7:0];
                CFG_INPUT_SCALE:       in_scale_reg    <= cfg_wdata[7:0];
                CFG_BATT_SCALE:        batt_scale_reg  <= cfg_wdata[7:0];
                CFG_KEY_MIN_VOLTAGE:   key_min_reg     <= cfg_wdata;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign capacity_pct    = out_cap_reg;
    assign input_volts     = out_in_reg;
    assign batt_volts      = out_batt_reg;
    assign power_connected = out_conn_reg;
    assign key_drive       = out_key_reg;

endmodule

/* hw/rtl/bgh_div.sv */
// Restoring divider, one quotient bit per cycle.
module bgh_div
    import bgh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bgh_div_req_t req,
    output bgh_div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
